FILE: rtl/rbbt_pkg.sv
// Shared types and constants for the red blob bounding-box tracker.
// No dependencies; every other file refers to this package by scoped names.
package rbbt_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_COLOR_TOTAL = 3'd0;
    localparam logic [2:0] REG_MIN_RED_COUNT   = 3'd1;
    localparam logic [2:0] REG_RATIO_NUM       = 3'd2;
    localparam logic [2:0] REG_RATIO_DEN       = 3'd3;
    localparam logic [2:0] REG_MOVE_LIMIT      = 3'd4;

    // Reset values of the configuration registers
    localparam logic [9:0]  RST_MIN_COLOR_TOTAL = 10'd60;
    localparam logic [16:0] RST_MIN_RED_COUNT   = 17'd50;
    localparam logic [3:0]  RST_RATIO_NUM       = 4'd7;
    localparam logic [3:0]  RST_RATIO_DEN       = 4'd5;
    localparam logic [8:0]  RST_MOVE_LIMIT      = 9'd20;

    // Tracking status codes
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_REF   = 2'd1;
    localparam logic [1:0] ST_SAFE  = 2'd2;
    localparam logic [1:0] ST_MOVED = 2'd3;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [9:0]  min_color_total;
        logic [16:0] min_red_count;
        logic [3:0]  ratio_num;
        logic [3:0]  ratio_den;
        logic [8:0]  move_limit;
    } cfg_t;

    // Frame summary handed from the accumulator to the tracker
    typedef struct packed {
        logic [16:0] count;
        logic [7:0]  top;
        logic [7:0]  bottom;
        logic [8:0]  left;
        logic [8:0]  right;
    } snap_t;

endpackage

FILE: rtl/rbbt_classify.sv
// Red pixel test: channel sum threshold and red dominance ratio.
// Depends on rbbt_pkg (cfg_t).
module rbbt_classify (
    input  logic [7:0]     red,
    input  logic [7:0]     green,
    input  logic [7:0]     blue,
    input  rbbt_pkg::cfg_t cfg,
    output logic           is_red
);

    logic [9:0]  sum;
    logic [11:0] red_scaled;
    logic [11:0] green_scaled;
    logic [11:0] blue_scaled;

    always_comb begin
        sum          = {2'b00, red} + {2'b00, green} + {2'b00, blue};
        red_scaled   = {4'd0, red}   * {8'd0, cfg.ratio_den};
        green_scaled = {4'd0, green} * {8'd0, cfg.ratio_num};
        blue_scaled  = {4'd0, blue}  * {8'd0, cfg.ratio_num};
        is_red = (sum > cfg.min_color_total) &&
                 (red_scaled > green_scaled) &&
                 (red_scaled > blue_scaled);
    end

endmodule

FILE: rtl/rbbt_accum.sv
// Pixel register and per-frame accumulation of red count and box extents.
// Emits a frame summary on the frame-end pixel. Depends on rbbt_pkg (snap_t).
module rbbt_accum #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_is_red,
    input  logic [7:0]        in_row,
    input  logic [8:0]        in_col,
    input  logic              in_last,
    output logic              snap_valid,
    output rbbt_pkg::snap_t   snap,
    input  logic              out_free
);

    // Wide enough to hold the empty-box marker
    localparam int ROW_W = (FRAME_HEIGHT > 255) ? $clog2(FRAME_HEIGHT + 1) : 8;
    localparam int COL_W = (FRAME_WIDTH > 511) ? $clog2(FRAME_WIDTH + 1) : 9;
    localparam logic [ROW_W-1:0] TOP_INIT  = ROW_W'(FRAME_HEIGHT);
    localparam logic [COL_W-1:0] LEFT_INIT = COL_W'(FRAME_WIDTH);

    logic             a_valid_reg, a_valid_next;
    logic             a_red_reg;
    logic [7:0]       a_row_reg;
    logic [8:0]       a_col_reg;
    logic             a_last_reg;

    logic [16:0]      count_reg, count_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic [7:0]       bottom_reg, bottom_next;
    logic [COL_W-1:0] left_reg, left_next;
    logic [8:0]       right_reg, right_next;

    logic             snap_valid_reg, snap_valid_next;
    rbbt_pkg::snap_t  snap_reg, snap_next;

    logic             snap_free;
    logic             a_move;
    logic [16:0]      count_upd;
    logic [ROW_W-1:0] top_upd;
    logic [7:0]       bottom_upd;
    logic [COL_W-1:0] left_upd;
    logic [8:0]       right_upd;

    always_comb begin
        snap_free = !snap_valid_reg || out_free;
        a_move    = a_valid_reg && (!a_last_reg || snap_free);
        in_ready  = !a_valid_reg || a_move;

        a_valid_next = in_ready ? in_valid : a_valid_reg;

        count_upd  = count_reg;
        top_upd    = top_reg;
        bottom_upd = bottom_reg;
        left_upd   = left_reg;
        right_upd  = right_reg;
        if (a_red_reg) begin
            if (count_reg != rbbt_pkg::COUNT_MAX) begin
                count_upd = count_reg + 17'd1;
            end
            if (ROW_W'(a_row_reg) < top_reg) begin
                top_upd = ROW_W'(a_row_reg);
            end
            if (a_row_reg > bottom_reg) begin
                bottom_upd = a_row_reg;
            end
            if (COL_W'(a_col_reg) < left_reg) begin
                left_upd = COL_W'(a_col_reg);
            end
            if (a_col_reg > right_reg) begin
                right_upd = a_col_reg;
            end
        end

        count_next      = count_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg && !out_free;

        if (a_move) begin
            if (a_last_reg) begin
                // Close the frame: hand over the summary and re-open the box
                snap_next.count  = count_upd;
                snap_next.top    = top_upd[7:0];
                snap_next.bottom = bottom_upd;
                snap_next.left   = left_upd[8:0];
                snap_next.right  = right_upd;
                snap_valid_next  = 1'b1;
                count_next       = '0;
                top_next         = TOP_INIT;
                bottom_next      = '0;
                left_next        = LEFT_INIT;
                right_next       = '0;
            end else begin
                count_next  = count_upd;
                top_next    = top_upd;
                bottom_next = bottom_upd;
                left_next   = left_upd;
                right_next  = right_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            snap_valid_reg <= 1'b0;
            count_reg      <= '0;
            top_reg        <= TOP_INIT;
            bottom_reg     <= '0;
            left_reg       <= LEFT_INIT;
            right_reg      <= '0;
        end else begin
            a_valid_reg    <= a_valid_next;
            snap_valid_reg <= snap_valid_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            a_red_reg  <= in_is_red;
            a_row_reg  <= in_row;
            a_col_reg  <= in_col;
            a_last_reg <= in_last;
        end
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

FILE: rtl/rbbt_track.sv
// Found decision, box centre, reference tracking and the result register.
// Depends on rbbt_pkg (cfg_t, snap_t, status codes).
module rbbt_track (
    input  logic            aclk,
    input  logic            aresetn,
    input  rbbt_pkg::cfg_t  cfg,
    input  logic            snap_valid,
    input  rbbt_pkg::snap_t snap,
    output logic            out_free,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_found,
    output logic [7:0]      m_box_top,
    output logic [7:0]      m_box_bottom,
    output logic [8:0]      m_box_left,
    output logic [8:0]      m_box_right,
    output logic [8:0]      m_center_x,
    output logic [7:0]      m_center_y,
    output logic [1:0]      m_track_status
);

    logic       m_valid_reg, m_valid_next;
    logic       found_reg, found_next;
    logic [7:0] top_reg, bottom_reg;
    logic [8:0] left_reg, right_reg;
    logic [8:0] cx_reg, cx_next;
    logic [7:0] cy_reg, cy_next;
    logic [1:0] status_reg, status_next;

    logic       ref_valid_reg, ref_valid_next;
    logic [8:0] ref_x_reg, ref_x_next;
    logic [7:0] ref_y_reg, ref_y_next;

    logic       take;
    logic [9:0] sum_x;
    logic [8:0] sum_y;
    logic [8:0] dx;
    logic [7:0] dy;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        take     = snap_valid && out_free;

        m_valid_next = take ? 1'b1 : (m_valid_reg && !m_ready);

        found_next = snap.count > cfg.min_red_count;
        sum_x      = {1'b0, snap.left} + {1'b0, snap.right};
        sum_y      = {1'b0, snap.top} + {1'b0, snap.bottom};
        cx_next    = found_next ? sum_x[9:1] : '0;
        cy_next    = found_next ? sum_y[8:1] : '0;

        dx = (cx_next >= ref_x_reg) ? (cx_next - ref_x_reg) : (ref_x_reg - cx_next);
        dy = (cy_next >= ref_y_reg) ? (cy_next - ref_y_reg) : (ref_y_reg - cy_next);

        ref_valid_next = ref_valid_reg;
        ref_x_next     = ref_x_reg;
        ref_y_next     = ref_y_reg;
        status_next    = rbbt_pkg::ST_NONE;

        if (found_next) begin
            if (!ref_valid_reg) begin
                status_next = rbbt_pkg::ST_REF;
                if (take) begin
                    ref_valid_next = 1'b1;
                    ref_x_next     = cx_next;
                    ref_y_next     = cy_next;
                end
            end else if (dx > cfg.move_limit || {1'b0, dy} > cfg.move_limit) begin
                status_next = rbbt_pkg::ST_MOVED;
            end else begin
                status_next = rbbt_pkg::ST_SAFE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            ref_valid_reg <= 1'b0;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
        end else begin
            m_valid_reg   <= m_valid_next;
            ref_valid_reg <= ref_valid_next;
            ref_x_reg     <= ref_x_next;
            ref_y_reg     <= ref_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            found_reg  <= found_next;
            top_reg    <= snap.top;
            bottom_reg <= snap.bottom;
            left_reg   <= snap.left;
            right_reg  <= snap.right;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            status_reg <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = found_reg;
    assign m_box_top      = top_reg;
    assign m_box_bottom   = bottom_reg;
    assign m_box_left     = left_reg;
    assign m_box_right    = right_reg;
    assign m_center_x     = cx_reg;
    assign m_center_y     = cy_reg;
    assign m_track_status = status_reg;

endmodule

FILE: rtl/red_blob_bbox_tracker_core.sv
// Top level of the red blob bounding-box tracker: configuration registers
// and the classify, accumulate and track stages. Depends on rbbt_pkg.
//
// Usage:
//   Pixels enter on the s_ channel, one beat per pixel with its row, column
//   and a frame_end flag on the last pixel of the frame. A beat can be taken
//   in every cycle while s_ready is high: one pixel per clock sustained.
//   Each pixel is tested for red (channel sum above a minimum, red dominating
//   green and blue by the programmed ratio) and folded into the running count
//   and box of the frame. Only a frame-end beat yields a result beat on the
//   m_ channel: box, centre, found flag and tracking status. Other beats give
//   nothing out.
//   Result path: the frame-end beat passes the input register, then the
//   accumulator/summary register, then the result register, to m_valid.
//   Stalls: a waiting result holds in the result register while pixels keep
//   flowing; only two frame ends in flight behind a stalled result hold off
//   s_ready, and nothing is dropped.
//   Configuration: cfg_valid/cfg_ready with a register index and data; always
//   ready; write only while the block is idle. Unknown indexes are ignored.
//   Reset (aresetn low, synchronous): registers take their defaults, the box
//   re-opens empty, the count clears and the tracking reference is dropped.
module red_blob_bbox_tracker_core #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_pix_row,
    input  logic [8:0]  s_pix_col,
    input  logic        s_frame_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [7:0]  m_box_top,
    output logic [7:0]  m_box_bottom,
    output logic [8:0]  m_box_left,
    output logic [8:0]  m_box_right,
    output logic [8:0]  m_center_x,
    output logic [7:0]  m_center_y,
    output logic [1:0]  m_track_status
);

    rbbt_pkg::cfg_t  cfg_reg, cfg_next;
    logic            pix_is_red;
    logic            snap_valid;
    rbbt_pkg::snap_t snap;
    logic            out_free;

    // Configuration writes: always accepted, out-of-range indexes dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                rbbt_pkg::REG_MIN_COLOR_TOTAL: cfg_next.min_color_total = cfg_data[9:0];
                rbbt_pkg::REG_MIN_RED_COUNT:   cfg_next.min_red_count   = cfg_data;
                rbbt_pkg::REG_RATIO_NUM:       cfg_next.ratio_num       = cfg_data[3:0];
                rbbt_pkg::REG_RATIO_DEN:       cfg_next.ratio_den       = cfg_data[3:0];
                rbbt_pkg::REG_MOVE_LIMIT:      cfg_next.move_limit      = cfg_data[8:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_color_total <= rbbt_pkg::RST_MIN_COLOR_TOTAL;
            cfg_reg.min_red_count   <= rbbt_pkg::RST_MIN_RED_COUNT;
            cfg_reg.ratio_num       <= rbbt_pkg::RST_RATIO_NUM;
            cfg_reg.ratio_den       <= rbbt_pkg::RST_RATIO_DEN;
            cfg_reg.move_limit      <= rbbt_pkg::RST_MOVE_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify on the incoming beat; the verdict is registered with the pixel
    rbbt_classify u_classify (
        .red    (s_red),
        .green  (s_green),
        .blue   (s_blue),
        .cfg    (cfg_reg),
        .is_red (pix_is_red)
    );

    // Fold pixels into the running box; hand over a summary at frame end
    rbbt_accum #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_is_red  (pix_is_red),
        .in_row     (s_pix_row),
        .in_col     (s_pix_col),
        .in_last    (s_frame_end),
        .snap_valid (snap_valid),
        .snap       (snap),
        .out_free   (out_free)
    );

    // Decide found, compute centre and status, hold the result beat
    rbbt_track u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .snap_valid     (snap_valid),
        .snap           (snap),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_box_top      (m_box_top),
        .m_box_bottom   (m_box_bottom),
        .m_box_left     (m_box_left),
        .m_box_right    (m_box_right),
        .m_center_x     (m_center_x),
        .m_center_y     (m_center_y),
        .m_track_status (m_track_status)
    );

endmodule

FILE: tb/sv/tb_red_blob_bbox_tracker_core.sv
// Self-checking bench for red_blob_bbox_tracker_core: directed and random pixel
// streams, with a predictor of the frame box checked against every result beat.
// Depends on rbbt_pkg and the core RTL only.
module tb_red_blob_bbox_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_WIDTH   = 320;
    localparam int FRAME_HEIGHT  = 240;
    localparam int SETTLE_CYCLES = 8;      // result passes the input, summary and result registers after frame end
    localparam int HOLD_CYCLES   = 200;    // long receiver hold-off
    localparam int CYCLE_LIMIT   = 20000;

    // One pixel beat as offered on the s_ channel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] row;
        logic [8:0] col;
        logic       frame_end;
    } pixel_t;

    // One frame result as seen on the m_ channel
    typedef struct packed {
        logic       found;
        logic [7:0] top;
        logic [7:0] bottom;
        logic [8:0] left;
        logic [8:0] right;
        logic [8:0] cx;
        logic [7:0] cy;
        logic [1:0] status;
    } box_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_red     = '0;
    logic [7:0]  s_green   = '0;
    logic [7:0]  s_blue    = '0;
    logic [7:0]  s_pix_row = '0;
    logic [8:0]  s_pix_col = '0;
    logic        s_frame_end = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_found;
    logic [7:0]  m_box_top;
    logic [7:0]  m_box_bottom;
    logic [8:0]  m_box_left;
    logic [8:0]  m_box_right;
    logic [8:0]  m_center_x;
    logic [7:0]  m_center_y;
    logic [1:0]  m_track_status;

    red_blob_bbox_tracker_core #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_pix_row     (s_pix_row),
        .s_pix_col     (s_pix_col),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_box_top     (m_box_top),
        .m_box_bottom  (m_box_bottom),
        .m_box_left    (m_box_left),
        .m_box_right   (m_box_right),
        .m_center_x    (m_center_x),
        .m_center_y    (m_center_y),
        .m_track_status(m_track_status)
    );

    // Pixels waiting for the driver, and frame results waiting for the DUT
    pixel_t pixel_q[$];
    box_t   due_boxes[$];

    // Predictor state: settings, running count and box, tracking anchor
    rbbt_pkg::cfg_t knobs;
    logic [16:0] hot_count;
    logic [7:0]  span_top;
    logic [7:0]  span_bottom;
    logic [8:0]  span_left;
    logic [8:0]  span_right;
    logic [8:0]  anchor_x;
    logic [7:0]  anchor_y;
    logic        anchor_set;

    // Run control shared between the stimulus thread and the port processes
    bit pix_taken = 1'b0;  // the beat on s_ was taken at the last rising edge
    bit calm      = 1'b0;  // no idling on either side
    int hold_req  = 0;     // bump to ask the receiver for one long hold-off
    int hold_seen = 0;
    int hold_left = 0;
    int src_gap   = 0;
    int sink_gap  = 0;

    int cycle_count   = 0;
    int errors        = 0;
    int pixels_taken  = 0;
    int frames_seen   = 0;
    int finds_seen    = 0;
    int moves_seen    = 0;
    int stalls_seen   = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Re-open the box empty and clear the count
    task automatic clear_span();
        hot_count   = '0;
        span_top    = 8'(FRAME_HEIGHT);
        span_bottom = '0;
        span_left   = 9'(FRAME_WIDTH);
        span_right  = '0;
    endtask

    // Fold one accepted pixel into the frame; on frame end queue the box due
    task automatic fold_pixel(input pixel_t p);
        int unsigned sum;
        int unsigned red_w;
        int unsigned grn_w;
        int unsigned blu_w;
        int unsigned dx;
        int unsigned dy;
        bit          hot;
        box_t        want;
        sum   = p.red + p.green + p.blue;
        red_w = p.red * knobs.ratio_den;
        grn_w = p.green * knobs.ratio_num;
        blu_w = p.blue * knobs.ratio_num;
        hot   = (sum > knobs.min_color_total) && (red_w > grn_w) && (red_w > blu_w);
        if (hot) begin
            // the count pins at its maximum rather than wrapping
            if (hot_count != rbbt_pkg::COUNT_MAX)
                hot_count = hot_count + 1'b1;
            if (p.row < span_top)    span_top    = p.row;
            if (p.row > span_bottom) span_bottom = p.row;
            if (p.col < span_left)   span_left   = p.col;
            if (p.col > span_right)  span_right  = p.col;
        end
        if (p.frame_end) begin
            want        = '0;
            want.found  = hot_count > knobs.min_red_count;
            want.top    = span_top;
            want.bottom = span_bottom;
            want.left   = span_left;
            want.right  = span_right;
            want.status = rbbt_pkg::ST_NONE;
            // a frame without a find leaves the centre at zero and the anchor alone
            if (want.found) begin
                want.cx = 9'((int'(span_left) + span_right) >> 1);
                want.cy = 8'((int'(span_top) + span_bottom) >> 1);
                if (!anchor_set) begin
                    anchor_x    = want.cx;
                    anchor_y    = want.cy;
                    anchor_set  = 1'b1;
                    want.status = rbbt_pkg::ST_REF;
                end else begin
                    dx = (want.cx > anchor_x) ? want.cx - anchor_x : anchor_x - want.cx;
                    dy = (want.cy > anchor_y) ? want.cy - anchor_y : anchor_y - want.cy;
                    want.status = (dx > knobs.move_limit || dy > knobs.move_limit) ?
                                  rbbt_pkg::ST_MOVED : rbbt_pkg::ST_SAFE;
                end
            end
            due_boxes.push_back(want);
            clear_span();
        end
    endtask

    function automatic string box_text(input box_t b);
        return $sformatf("found=%0d top=%0d bottom=%0d left=%0d right=%0d cx=%0d cy=%0d st=%0d",
                         b.found, b.top, b.bottom, b.left, b.right, b.cx, b.cy, b.status);
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: present beats at the falling edge, hold until taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_pixels
        pixel_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pix_taken) begin
            if (src_gap != 0) begin
                // idle burst after the previous beat
                src_gap = src_gap - 1;
                s_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                nxt = pixel_q.pop_front();
                s_valid     <= 1'b1;
                s_red       <= nxt.red;
                s_green     <= nxt.green;
                s_blue      <= nxt.blue;
                s_pix_row   <= nxt.row;
                s_pix_col   <= nxt.col;
                s_frame_end <= nxt.frame_end;
                if (!calm && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
        // otherwise hold the beat unchanged until it is taken
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            // start the long hold-off; the sender keeps pushing meanwhile
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap = sink_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                sink_gap = $urandom_range(1, 4);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, check and predict
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_ports
        box_t   got;
        box_t   want;
        pixel_t seen;
        string  bad;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else if (!aresetn) begin
            pix_taken <= 1'b0;
        end else begin
            // check results first: they stem from beats taken at earlier edges
            if (m_valid && m_ready) begin
                got = '{m_found, m_box_top, m_box_bottom, m_box_left, m_box_right,
                        m_center_x, m_center_y, m_track_status};
                frames_seen = frames_seen + 1;
                if (got.found) finds_seen = finds_seen + 1;
                if (got.status == rbbt_pkg::ST_MOVED) moves_seen = moves_seen + 1;
                if (due_boxes.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: result beat with nothing due, actual %s",
                             $time, box_text(got));
                end else begin
                    want = due_boxes.pop_front();
                    bad  = "";
                    if (got.found  !== want.found)  bad = {bad, " found"};
                    if (got.top    !== want.top)    bad = {bad, " box_top"};
                    if (got.bottom !== want.bottom) bad = {bad, " box_bottom"};
                    if (got.left   !== want.left)   bad = {bad, " box_left"};
                    if (got.right  !== want.right)  bad = {bad, " box_right"};
                    if (got.cx     !== want.cx)     bad = {bad, " center_x"};
                    if (got.cy     !== want.cy)     bad = {bad, " center_y"};
                    if (got.status !== want.status) bad = {bad, " track_status"};
                    if (bad.len() != 0) begin
                        errors = errors + 1;
                        $display("%0t: mismatch in%s: expected %s, actual %s",
                                 $time, bad, box_text(want), box_text(got));
                    end
                end
            end
            if (s_valid && !s_ready)
                stalls_seen = stalls_seen + 1;
            if (s_valid && s_ready) begin
                seen = '{s_red, s_green, s_blue, s_pix_row, s_pix_col, s_frame_end};
                pixels_taken = pixels_taken + 1;
                fold_pixel(seen);
            end
            pix_taken <= s_valid && s_ready;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One register beat; mirror it into the predictor once taken
    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 17'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            rbbt_pkg::REG_MIN_COLOR_TOTAL: knobs.min_color_total = 10'(value);
            rbbt_pkg::REG_MIN_RED_COUNT:   knobs.min_red_count   = 17'(value);
            rbbt_pkg::REG_RATIO_NUM:       knobs.ratio_num       = 4'(value);
            rbbt_pkg::REG_RATIO_DEN:       knobs.ratio_den       = 4'(value);
            rbbt_pkg::REG_MOVE_LIMIT:      knobs.move_limit      = 9'(value);
            default: ;
        endcase
    endtask

    // Write the full register set back to back, then drop the valid
    task automatic program_knobs(input int unsigned color_min, input int unsigned count_min,
                                 input int unsigned num, input int unsigned den,
                                 input int unsigned move);
        write_reg(rbbt_pkg::REG_MIN_COLOR_TOTAL, color_min);
        write_reg(rbbt_pkg::REG_MIN_RED_COUNT, count_min);
        write_reg(rbbt_pkg::REG_RATIO_NUM, num);
        write_reg(rbbt_pkg::REG_RATIO_DEN, den);
        write_reg(rbbt_pkg::REG_MOVE_LIMIT, move);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input int r, input int g, input int b,
                              input int row, input int col, input bit last);
        pixel_t p;
        p = '{8'(r), 8'(g), 8'(b), 8'(row), 9'(col), last};
        pixel_q.push_back(p);
    endtask

    // Hot pixels favour red under the default ratio; the rest are any colour.
    // A few coordinates stray outside the frame to reach every field bit.
    function automatic pixel_t make_pixel(input bit hot);
        pixel_t p;
        if (hot) begin
            p.red   = 8'($urandom_range(100, 255));
            p.green = 8'($urandom_range(0, p.red / 2));
            p.blue  = 8'($urandom_range(0, p.red / 2));
        end else begin
            p.red   = 8'($urandom_range(0, 255));
            p.green = 8'($urandom_range(0, 255));
            p.blue  = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 11) == 0) begin
            p.row = 8'($urandom_range(0, 255));
            p.col = 9'($urandom_range(0, 511));
        end else begin
            p.row = 8'($urandom_range(0, FRAME_HEIGHT - 1));
            p.col = 9'($urandom_range(0, FRAME_WIDTH - 1));
        end
        p.frame_end = 1'b0;
        return p;
    endfunction

    // Queue short frames of random length, each closed by a frame-end beat
    task automatic queue_frames(input int n_pixels, input int max_len);
        int     made;
        int     len;
        pixel_t p;
        made = 0;
        while (made < n_pixels) begin
            len = $urandom_range(1, max_len);
            for (int k = 0; k < len; k++) begin
                p = make_pixel($urandom_range(0, 9) < 6);
                p.frame_end = (k == len - 1);
                pixel_q.push_back(p);
                made = made + 1;
            end
        end
    endtask

    // Wait until every pixel is taken and every result has come, then let
    // the pipeline empty before anything touches the registers
    task automatic settle();
        while (pixel_q.size() != 0 || s_valid || due_boxes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_knobs_phase(input int n_pixels);
        program_knobs($urandom_range(0, 400), $urandom_range(0, 6), $urandom_range(1, 15),
                      $urandom_range(1, 15), $urandom_range(0, 60));
        queue_frames(n_pixels, 10);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_sequence
        knobs = '{rbbt_pkg::RST_MIN_COLOR_TOTAL, rbbt_pkg::RST_MIN_RED_COUNT,
                  rbbt_pkg::RST_RATIO_NUM, rbbt_pkg::RST_RATIO_DEN,
                  rbbt_pkg::RST_MOVE_LIMIT};
        clear_span();
        anchor_x   = '0;
        anchor_y   = '0;
        anchor_set = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: default ratio and limits, one red pixel enough for a find
        program_knobs(60, 0, 7, 5, 20);
        push_pixel(0, 0, 0, 0, 0, 1);             // empty frame: box stays open
        push_pixel(255, 0, 0, 0, 0, 0);
        push_pixel(255, 0, 0, 239, 319, 1);       // first find latches the anchor
        push_pixel(200, 10, 10, 120, 160, 1);     // near the anchor: safe
        push_pixel(255, 0, 0, 0, 0, 1);           // far corner: moved
        push_pixel(60, 0, 0, 5, 5, 0);            // sum equal to the minimum: not red
        push_pixel(61, 0, 0, 6, 6, 1);            // one above: red
        push_pixel(140, 100, 0, 10, 10, 0);       // red*den equals green*num: not red
        push_pixel(140, 0, 100, 11, 11, 0);       // same against blue
        push_pixel(141, 100, 100, 12, 12, 1);     // just above both
        push_pixel(255, 255, 255, 255, 511, 1);   // white is not red
        push_pixel(255, 0, 0, 255, 511, 1);       // coordinates past the frame
        push_pixel(0, 255, 255, 100, 300, 0);
        push_pixel(255, 0, 0, 200, 40, 0);
        push_pixel(255, 0, 0, 30, 280, 1);
        settle();

        // Random frames under one register set
        program_knobs(60, 2, 7, 5, 20);
        queue_frames(70, 10);
        settle();

        // Lowest thresholds: nearly everything counts, any shift is a move
        program_knobs(0, 0, 1, 15, 0);
        queue_frames(60, 8);
        settle();

        // Highest in-range thresholds, then every field at its top value
        program_knobs(765, 76800, 15, 1, 319);
        queue_frames(40, 10);
        settle();
        program_knobs(1023, 131071, 15, 15, 511);
        queue_frames(30, 10);
        settle();

        // Zero ratio registers, taken as written
        program_knobs(100, 1, 0, 3, 30);
        queue_frames(50, 8);
        settle();
        program_knobs(100, 1, 4, 0, 30);
        queue_frames(30, 8);
        settle();

        random_knobs_phase(60);
        random_knobs_phase(60);

        // Back-pressure: hold the receiver off while short frames keep coming,
        // so frame ends pile up behind the stalled result and s_ready drops
        program_knobs(40, 0, 7, 5, 20);
        hold_req = hold_req + 1;
        queue_frames(80, 2);
        settle();

        // Last part without idling on either side
        calm = 1'b1;
        random_knobs_phase(60);

        $display("Covered %0d pixel beats and %0d frame results (%0d finds, %0d moves),",
                 pixels_taken, frames_seen, finds_seen, moves_seen);
        $display("with %0d input stall cycles across eleven register sets.",
                 stalls_seen);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
